[hdl/ncc_pkg.sv]
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants for the nearest colour classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

   localparam int SENSOR_COUNT = 9;
   localparam int COLOR_COUNT  = 7;

   localparam int SENS_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int IDX_W   = 4;
   localparam int COLOR_W = 3;
   localparam int LEVEL_W = 11;
   localparam int DIST_W  = 12;
   localparam int STAT_W  = 2;
   localparam int ENTRY_W = 32;
   localparam int SUM_W   = 23;                 // 4 * 1279^2 < 2^23
   localparam int ROOT_STEPS = (SUM_W + 1) / 2; // one root bit per step
   localparam int STEP_W  = 4;

   localparam logic [COLOR_W-1:0] UNKNOWN_COLOR = 3'd7;
   localparam logic [DIST_W-1:0]  NO_MATCH_DIST = 12'd999;
   localparam logic [DIST_W-1:0]  TOL_RESET     = 12'd4095;

   localparam logic KIND_WRITE    = 1'b0;
   localparam logic KIND_CLASSIFY = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_SENSOR = 2'd1,
      STAT_BAD_COLOR  = 2'd2,
      STAT_BAD_LEVEL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_SQUARE,
      S_ROOT,
      S_MERGE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic              sq_en;
      logic              sq_clear;
      logic [1:0]        ch_sel;
      logic              rt_init;
      logic              rt_en;
      logic [SENS_W-1:0] addr;
   } lane_ctl_type;

endpackage

[hdl/ncc_lane.sv]
// ----------------------------------------------------------------------------
// ncc_lane
// One colour lane: per-sensor reference store, serial squared distance and
// a bit-per-cycle integer square root.
// ----------------------------------------------------------------------------
module ncc_lane
   import ncc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctl_type              ctl,
   input  logic                      wr_sel,
   input  logic [ENTRY_W-1:0]        wr_data,
   input  logic signed [LEVEL_W-1:0] samp_level,
   output logic [DIST_W-1:0]         distance
);

   logic [ENTRY_W-1:0] mem_ff [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] valid_ff;
   logic [ENTRY_W-1:0] rd_ff;

   logic [7:0]           ref_level;
   logic signed [11:0]   diff;
   logic [11:0]          diff_abs;
   logic [21:0]          sq;
   logic [SUM_W-1:0]     acc_ff, acc_in;

   logic [SUM_W-1:0]     x_ff, x_in;
   logic [SUM_W-1:0]     root_ff, root_in;
   logic [SUM_W-1:0]     bit_ff, bit_in;
   logic [SUM_W:0]       trial;

   // store: written on a good write, read registered; unwritten reads as zero
   always_ff @(posedge clock) begin
      if (ctl.wr_en && wr_sel) begin
         mem_ff[ctl.addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= valid_ff[ctl.addr] ? mem_ff[ctl.addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en && wr_sel) begin
         valid_ff[ctl.addr] <= 1'b1;
      end
   end

   // one channel squared per cycle
   always_comb begin
      ref_level = rd_ff[8*ctl.ch_sel +: 8];
      diff      = $signed({samp_level[LEVEL_W-1], samp_level}) - $signed({4'b0, ref_level});
      diff_abs  = diff[11] ? 12'(-diff) : 12'(diff);
      sq        = diff_abs[10:0] * diff_abs[10:0];
      acc_in    = (ctl.sq_clear ? '0 : acc_ff) + SUM_W'(sq);
   end

   always_ff @(posedge clock) begin
      if (ctl.sq_en) begin
         acc_ff <= acc_in;
      end
   end

   // restoring square root
   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      x_in    = x_ff;
      root_in = root_ff >> 1;
      bit_in  = bit_ff >> 2;
      if ({1'b0, x_ff} >= trial) begin
         x_in    = x_ff - trial[SUM_W-1:0];
         root_in = (root_ff >> 1) + bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rt_init) begin
         x_ff    <= acc_ff;
         root_ff <= '0;
         bit_ff  <= {1'b1, {(SUM_W-1){1'b0}}};
      end else if (ctl.rt_en) begin
         x_ff    <= x_in;
         root_ff <= root_in;
         bit_ff  <= bit_in;
      end
   end

   assign distance = root_ff[DIST_W-1:0];

endmodule

[hdl/ncc_merge.sv]
// ----------------------------------------------------------------------------
// ncc_merge
// Picks the first lane with the smallest distance below the no-match mark
// and applies the tolerance.
// ----------------------------------------------------------------------------
module ncc_merge
   import ncc_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [DIST_W-1:0]  distance [COLOR_COUNT],
   input  logic [DIST_W-1:0]  tolerance,
   output logic [COLOR_W-1:0] best_color,
   output logic [DIST_W-1:0]  best_dist
);

   logic [COLOR_W-1:0] color_ff, color_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;

   always_comb begin
      dist_in  = NO_MATCH_DIST;
      color_in = UNKNOWN_COLOR;
      for (int c = 0; c < COLOR_COUNT; c++) begin
         if (distance[c] < dist_in) begin   // strict: earlier colour wins ties
            dist_in  = distance[c];
            color_in = COLOR_W'(c);
         end
      end
      if (dist_in > tolerance) begin
         color_in = UNKNOWN_COLOR;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         color_ff <= color_in;
         dist_ff  <= dist_in;
      end
   end

   assign best_color = color_ff;
   assign best_dist  = dist_ff;

endmodule

[hdl/nearest_color_classifier.sv]
// ----------------------------------------------------------------------------
// nearest_color_classifier
// Nearest-centroid colour classifier with a per-sensor calibration table.
//
// Each request transfer either stores one RGBW reference vector (kind 0) for a
// sensor and colour, or classifies a sample (kind 1) against the seven
// references of its sensor. The table reads as zero after reset. Writes are
// checked in the order sensor index, colour code, channel range (0..255) and
// return a status; classification returns the first colour with the smallest
// truncated Euclidean distance below 999, or unknown (7) when that distance
// exceeds csr match tolerance. Seven colour lanes run side by side, one
// reference each; every lane squares one channel per cycle and then takes a
// square root one bit per cycle. A classification passes through a table
// read, 4 squaring steps, 13 root steps of which the first loads the sum,
// a merge and an output load. A write or a bad-sensor classification
// passes through one check step and then the output load. One item is
// worked on at a time; a finished result sits in the output register, so
// the next request is taken while the result still waits; only a second
// finished result, with the first still unread, stalls the request side.
// ----------------------------------------------------------------------------
module nearest_color_classifier
   import ncc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [IDX_W-1:0]          req_sensor_index,
   input  logic [COLOR_W-1:0]        req_color_code,
   input  logic signed [LEVEL_W-1:0] req_red_level,
   input  logic signed [LEVEL_W-1:0] req_green_level,
   input  logic signed [LEVEL_W-1:0] req_blue_level,
   input  logic signed [LEVEL_W-1:0] req_white_level,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [COLOR_W-1:0]        rsp_matched_color,
   output logic [DIST_W-1:0]         rsp_match_distance,

   input  logic                      csr_wr_en,
   input  logic [DIST_W-1:0]         csr_wr_data
);

   // control
   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   lane_ctl_type       ctl;

   // latched request
   logic [IDX_W-1:0]          sensor_ff;
   logic [COLOR_W-1:0]        color_ff;
   logic signed [LEVEL_W-1:0] level_ff [4];

   // held result for writes and bad-sensor classifications
   status_type         res_status_ff, res_status_in;
   logic [COLOR_W-1:0] res_color_ff, res_color_in;
   logic [DIST_W-1:0]  res_dist_ff, res_dist_in;
   logic               from_merge_ff, from_merge_in;
   logic               res_load;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_load;

   logic [DIST_W-1:0]  tol_ff;

   logic               req_take;
   logic               sensor_bad;
   logic               level_bad;
   status_type         wr_status;
   logic [ENTRY_W-1:0] wr_data;
   logic signed [LEVEL_W-1:0] samp_level;

   logic [DIST_W-1:0]  lane_dist [COLOR_COUNT];
   logic [COLOR_W-1:0] best_color;
   logic [DIST_W-1:0]  best_dist;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         sensor_ff   <= req_sensor_index;
         color_ff    <= req_color_code;
         level_ff[0] <= req_red_level;
         level_ff[1] <= req_green_level;
         level_ff[2] <= req_blue_level;
         level_ff[3] <= req_white_level;
      end
   end

   // write checks, in priority order: sensor, colour, channel range
   always_comb begin
      sensor_bad = {1'b0, sensor_ff} >= (IDX_W+1)'(SENSOR_COUNT);
      level_bad  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (level_ff[i][LEVEL_W-1:8] != '0) begin
            level_bad = 1'b1;
         end
         wr_data[8*i +: 8] = level_ff[i][7:0];
      end
      if (sensor_bad) begin
         wr_status = STAT_BAD_SENSOR;
      end else if ({1'b0, color_ff} >= (COLOR_W+1)'(COLOR_COUNT)) begin
         wr_status = STAT_BAD_COLOR;
      end else if (level_bad) begin
         wr_status = STAT_BAD_LEVEL;
      end else begin
         wr_status = STAT_OK;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      ctl           = '0;
      ctl.addr      = sensor_ff[SENS_W-1:0];
      ctl.ch_sel    = step_ff[1:0];
      res_load      = 1'b0;
      res_status_in = res_status_ff;
      res_color_in  = res_color_ff;
      res_dist_in   = res_dist_ff;
      from_merge_in = from_merge_ff;
      rsp_load      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = (req_kind == KIND_WRITE) ? S_WRITE : S_READ;
            end
         end
         S_WRITE: begin
            ctl.wr_en     = (wr_status == STAT_OK);
            res_load      = 1'b1;
            res_status_in = wr_status;
            res_color_in  = '0;
            res_dist_in   = '0;
            from_merge_in = 1'b0;
            state_in      = S_DONE;
         end
         S_READ: begin
            if (sensor_bad) begin
               // no table access for an unknown sensor
               res_load      = 1'b1;
               res_status_in = STAT_BAD_SENSOR;
               res_color_in  = UNKNOWN_COLOR;
               res_dist_in   = NO_MATCH_DIST;
               from_merge_in = 1'b0;
               state_in      = S_DONE;
            end else begin
               ctl.rd_en = 1'b1;
               step_in   = '0;
               state_in  = S_SQUARE;
            end
         end
         S_SQUARE: begin
            ctl.sq_en    = 1'b1;
            ctl.sq_clear = (step_ff == '0);
            if (step_ff == STEP_W'(3)) begin
               step_in  = '0;
               state_in = S_ROOT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ROOT: begin
            // step 0 loads the sum, then one root bit per step
            ctl.rt_init = (step_ff == '0);
            ctl.rt_en   = (step_ff != '0);
            if (step_ff == STEP_W'(ROOT_STEPS)) begin
               state_in = S_MERGE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MERGE: begin
            res_load      = 1'b1;
            from_merge_in = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_status_ff <= res_status_in;
         res_color_ff  <= res_color_in;
         res_dist_ff   <= res_dist_in;
         from_merge_ff <= from_merge_in;
      end
   end

   // lanes, one per colour
   assign samp_level = level_ff[step_ff[1:0]];

   for (genvar g = 0; g < COLOR_COUNT; g++) begin : g_lane
      ncc_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_sel     (color_ff == COLOR_W'(g)),
         .wr_data    (wr_data),
         .samp_level (samp_level),
         .distance   (lane_dist[g])
      );
   end

   ncc_merge u_merge (
      .clock      (clock),
      .en         (state_ff == S_MERGE),
      .distance   (lane_dist),
      .tolerance  (tol_ff),
      .best_color (best_color),
      .best_dist  (best_dist)
   );

   // output register: a held result does not block the next request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (from_merge_ff) begin
            rsp_status_ff <= STAT_OK;
            rsp_color_ff  <= best_color;
            rsp_dist_ff   <= best_dist;
         end else begin
            rsp_status_ff <= res_status_ff;
            rsp_color_ff  <= res_color_ff;
            rsp_dist_ff   <= res_dist_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_matched_color  = rsp_color_ff;
   assign rsp_match_distance = rsp_dist_ff;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_color_classifier. Drives calibration writes
// and classification requests through the valid/stall request channel, keeps
// its own copy of the calibration table and match tolerance, predicts every
// response and compares it field by field as the response transfers.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ncc_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
   localparam int PHASE_ITEMS    = 90;
   localparam int HOLD_OFF_LEN   = 150;

   // colour codes in table order
   typedef enum logic [COLOR_W-1:0] {
      COL_R, COL_G, COL_B, COL_Y, COL_O, COL_W, COL_E
   } colour_code_type;

   typedef struct {
      logic                      kind;
      logic [IDX_W-1:0]          sensor;
      logic [COLOR_W-1:0]        colour;
      logic signed [LEVEL_W-1:0] level [4];   // R, G, B, W
   } request_type;

   typedef struct {
      status_type         status;
      logic [COLOR_W-1:0] colour;
      logic [DIST_W-1:0]  distance;
   } outcome_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow calibration table + queue of predicted responses
   // -------------------------------------------------------------------------
   class classifier_scoreboard;
      logic [DIST_W-1:0] tolerance;
      logic [7:0]        cal_level [SENSOR_COUNT][COLOR_COUNT][4];
      outcome_type       expected_results [$];
      int errors, n_write, n_rejected, n_classify, n_matched, n_unknown, n_bad_sensor;

      function new();
         tolerance = TOL_RESET;
         foreach (cal_level[s, c, i]) cal_level[s][c][i] = '0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // truncated square root, one result bit per pass
      function int unsigned int_root(int unsigned v);
         int unsigned r, t;
         r = 0;
         for (int b = DIST_W - 1; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      // called once per accepted request transfer
      function void log_request(request_type r);
         outcome_type o;
         int          lv [4];
         int          d;
         int unsigned sum, span;
         foreach (lv[i]) lv[i] = int'(r.level[i]);
         o.status   = STAT_OK;
         o.colour   = '0;
         o.distance = '0;
         if (r.kind == KIND_WRITE) begin
            n_write++;
            if (r.sensor >= SENSOR_COUNT) o.status = STAT_BAD_SENSOR;
            else if (r.colour >= COLOR_COUNT) o.status = STAT_BAD_COLOR;
            else foreach (lv[i]) if (lv[i] < 0 || lv[i] > 255) o.status = STAT_BAD_LEVEL;
            if (o.status == STAT_OK) begin
               foreach (lv[i]) cal_level[r.sensor][r.colour][i] = lv[i][7:0];
            end else begin
               n_rejected++;
            end
         end else if (r.sensor >= SENSOR_COUNT) begin
            n_classify++;
            n_bad_sensor++;
            o.status   = STAT_BAD_SENSOR;
            o.colour   = UNKNOWN_COLOR;
            o.distance = NO_MATCH_DIST;
         end else begin
            n_classify++;
            o.colour   = UNKNOWN_COLOR;
            o.distance = NO_MATCH_DIST;
            for (int c = 0; c < COLOR_COUNT; c++) begin
               sum = 0;
               foreach (lv[i]) begin
                  d = lv[i] - int'(cal_level[r.sensor][c][i]);
                  sum += d * d;
               end
               span = int_root(sum);
               // strict compare: earlier colour keeps a tie
               if (span < o.distance) begin
                  o.distance = DIST_W'(span);
                  o.colour   = COLOR_W'(c);
               end
            end
            if (o.distance > tolerance) o.colour = UNKNOWN_COLOR;
            if (o.colour == UNKNOWN_COLOR) n_unknown++;
            else n_matched++;
         end
         expected_results.push_back(o);
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(logic [STAT_W-1:0] st, logic [COLOR_W-1:0] col,
                        logic [DIST_W-1:0] distance);
         outcome_type o;
         if (expected_results.size() == 0) begin
            report($sformatf("response with none pending: status %0d colour %0d dist %0d",
                             st, col, distance));
            return;
         end
         o = expected_results.pop_front();
         if (st !== o.status)
            report($sformatf("status %0d, predicted %0d", st, o.status));
         if (col !== o.colour)
            report($sformatf("matched_color %0d, predicted %0d", col, o.colour));
         if (distance !== o.distance)
            report($sformatf("match_distance %0d, predicted %0d", distance, o.distance));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // -------------------------------------------------------------------------
   logic                      clock;
   logic                      reset              = 1'b1;
   logic                      req_valid          = 1'b0;
   logic                      req_stall;
   logic                      req_kind           = KIND_WRITE;
   logic [IDX_W-1:0]          req_sensor_index   = '0;
   logic [COLOR_W-1:0]        req_color_code     = '0;
   logic signed [LEVEL_W-1:0] req_red_level      = '0;
   logic signed [LEVEL_W-1:0] req_green_level    = '0;
   logic signed [LEVEL_W-1:0] req_blue_level     = '0;
   logic signed [LEVEL_W-1:0] req_white_level    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall          = 1'b0;
   logic [STAT_W-1:0]         rsp_status;
   logic [COLOR_W-1:0]        rsp_matched_color;
   logic [DIST_W-1:0]         rsp_match_distance;
   logic                      csr_wr_en          = 1'b0;
   logic [DIST_W-1:0]         csr_wr_data        = '0;

   classifier_scoreboard sb;

   int send_idle_pct   = 0;   // chance per cycle the sender holds back
   int rsp_stall_pct   = 0;   // chance per cycle the receiver stalls
   int hold_off_cycles = 0;   // long receiver hold-off, counted down below
   int quiet_cycles    = 0;
   int tol_settings    = 0;

   nearest_color_classifier uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_sensor_index   (req_sensor_index),
      .req_color_code     (req_color_code),
      .req_red_level      (req_red_level),
      .req_green_level    (req_green_level),
      .req_blue_level     (req_blue_level),
      .req_white_level    (req_white_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_matched_color  (rsp_matched_color),
      .rsp_match_distance (rsp_match_distance),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   // Driven at the rising edge; it is stable by the falling edge.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // Monitor and watchdog. Inputs and DUT state only move at the rising edge,
   // so what is seen at the falling edge is exactly what the next rising edge
   // acts on: a response seen here with valid high and stall low transfers
   // at that edge.
   always @(negedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_matched_color, rsp_match_distance);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d responses pending",
                     quiet_cycles, sb.pending());
            $display("FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic request_type make_request(logic kind, int sensor,
                                                logic [COLOR_W-1:0] colour,
                                                int red, int green, int blue, int white);
      request_type r;
      r.kind     = kind;
      r.sensor   = IDX_W'(sensor);
      r.colour   = colour;
      r.level[0] = LEVEL_W'(red);
      r.level[1] = LEVEL_W'(green);
      r.level[2] = LEVEL_W'(blue);
      r.level[3] = LEVEL_W'(white);
      return r;
   endfunction

   // Mostly legal writes and samples near a stored reference, so that the
   // tolerance and tie logic is exercised; the rest is partly out of range.
   function automatic request_type random_request();
      request_type r;
      int          pick, c;
      bit          exact;
      r.kind   = ($urandom_range(99) < 45) ? KIND_WRITE : KIND_CLASSIFY;
      r.sensor = ($urandom_range(99) < 88) ? IDX_W'($urandom_range(SENSOR_COUNT - 1))
                                           : IDX_W'($urandom_range(15, SENSOR_COUNT));
      r.colour = ($urandom_range(99) < 90) ? COLOR_W'($urandom_range(COLOR_COUNT - 1))
                                           : COLOR_W'($urandom_range(7, COLOR_COUNT));
      pick = $urandom_range(99);
      if (r.kind == KIND_WRITE) begin
         foreach (r.level[i])
            r.level[i] = (pick < 85) ? LEVEL_W'($urandom_range(255)) : LEVEL_W'($urandom);
      end else if (pick < 60 && r.sensor < SENSOR_COUNT) begin
         c     = $urandom_range(COLOR_COUNT - 1);
         exact = ($urandom_range(99) < 40);
         foreach (r.level[i])
            r.level[i] = LEVEL_W'(int'(sb.cal_level[r.sensor][c][i])
                                  + (exact ? 0 : int'($urandom_range(60)) - 30));
      end else if (pick < 80) begin
         foreach (r.level[i]) r.level[i] = LEVEL_W'($urandom_range(255));
      end else begin
         foreach (r.level[i]) r.level[i] = LEVEL_W'($urandom);
      end
      return r;
   endfunction

   // Offer one request and hold it until it transfers. Entered and left at a
   // rising edge, so valid gets at most one assignment per time step.
   task automatic send_request(request_type r);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= r.kind;
      req_sensor_index <= r.sensor;
      req_color_code   <= r.colour;
      req_red_level    <= r.level[0];
      req_green_level  <= r.level[1];
      req_blue_level   <= r.level[2];
      req_white_level  <= r.level[3];
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sb.log_request(r);
   endtask

   // stop offering and wait for every predicted response
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // only called with the block idle, so the shadow copy can follow at once
   task automatic set_tolerance(logic [DIST_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.tolerance = value;
      tol_settings++;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset tolerance. Zeroed table: all colours tie,
      // first one wins; a distance of exactly 999 is not a match.
      send_request(make_request(KIND_CLASSIFY, 0, COL_R, 0, 0, 0, 0));
      send_request(make_request(KIND_CLASSIFY, 8, UNKNOWN_COLOR, 999, 0, 0, 0));
      send_request(make_request(KIND_CLASSIFY, 8, COL_Y, 998, 0, 0, 0));
      // bad sensor on classify; colour code is ignored there
      send_request(make_request(KIND_CLASSIFY, 9, COL_R, 10, 10, 10, 10));
      send_request(make_request(KIND_CLASSIFY, 15, COL_W, -1024, 1023, -1, 0));
      // write checks: sensor before colour before channel range
      send_request(make_request(KIND_WRITE, 9, UNKNOWN_COLOR, -1, 0, 0, 0));
      send_request(make_request(KIND_WRITE, 15, COL_R, 1, 2, 3, 4));
      send_request(make_request(KIND_WRITE, 0, UNKNOWN_COLOR, 300, 0, 0, 0));
      send_request(make_request(KIND_WRITE, 0, COL_R, -1, 0, 0, 0));
      send_request(make_request(KIND_WRITE, 0, COL_G, 0, 0, 0, 256));
      send_request(make_request(KIND_WRITE, 0, COL_B, 0, 1023, 0, 0));
      send_request(make_request(KIND_WRITE, 0, COL_Y, 0, 0, -1024, 0));
      // accepted writes, incl. a duplicate reference to exercise the tie rule
      send_request(make_request(KIND_WRITE, 0, COL_R, 255, 255, 255, 255));
      send_request(make_request(KIND_WRITE, 8, COL_E, 1, 2, 3, 4));
      send_request(make_request(KIND_WRITE, 1, COL_B, 100, 50, 25, 200));
      send_request(make_request(KIND_WRITE, 1, COL_O, 100, 50, 25, 200));
      send_request(make_request(KIND_CLASSIFY, 1, COL_R, 100, 50, 25, 200));
      send_request(make_request(KIND_CLASSIFY, 1, COL_R, 110, 50, 25, 200));
      // channel extremes: differences far beyond the 0..255 range
      send_request(make_request(KIND_CLASSIFY, 0, COL_R, -1024, -1024, -1024, -1024));
      send_request(make_request(KIND_CLASSIFY, 0, COL_R, 1023, 1023, 1023, 1023));
      send_request(make_request(KIND_CLASSIFY, 0, COL_R, 255, 255, 255, 255));
      send_request(make_request(KIND_CLASSIFY, 8, COL_R, 1, 2, 3, 4));
      send_request(make_request(KIND_WRITE, 2, COL_E, 255, 0, 255, 0));

      // Random phases, each with its own tolerance and flow-control pattern
      for (int p = 0; p < 5; p++) begin
         drain();
         case (p)
            0: begin
               send_idle_pct = 0;  rsp_stall_pct = 0;
               set_tolerance('0);
            end
            1: begin
               send_idle_pct = 73; rsp_stall_pct = 0;
               set_tolerance(TOL_RESET);
            end
            2: begin
               send_idle_pct = 0;  rsp_stall_pct = 73;
               set_tolerance(DIST_W'($urandom_range(20, 400)));
            end
            3: begin
               send_idle_pct = 38; rsp_stall_pct = 38;
               set_tolerance(DIST_W'(NO_MATCH_DIST - 1));
            end
            default: begin
               // long output hold-off while requests keep coming: the block
               // fills and must stall its request side
               send_idle_pct = 0;  rsp_stall_pct = 0;
               set_tolerance(DIST_W'($urandom_range(0, 4095)));
               hold_off_cycles = HOLD_OFF_LEN;
            end
         endcase
         repeat (PHASE_ITEMS) send_request(random_request());
      end

      drain();
      repeat (40) @(posedge clock);   // catch any stray late response

      if (sb.pending() != 0)
         sb.report($sformatf("%0d predicted responses never arrived", sb.pending()));
      $display("Covered %0d writes (%0d rejected) and %0d classifications",
               sb.n_write, sb.n_rejected, sb.n_classify);
      $display("  (%0d matched, %0d unknown, %0d bad sensor) over %0d tolerance settings",
               sb.n_matched, sb.n_unknown, sb.n_bad_sensor, tol_settings);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/ncc_pkg.sv
hdl/ncc_lane.sv
hdl/ncc_merge.sv
hdl/nearest_color_classifier.sv
dv/testbench.sv
